/* hdl/cm2d_pkg.sv */
`default_nettype none
package cm2d_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 15;
    localparam int ROUND_SHIFT = 14;

    localparam logic signed [15:0] NORM_POS = 16'sd16384;
    localparam logic signed [15:0] NORM_NEG = -16'sd16384;

    typedef enum logic [1:0] {
        OP_CIRCLE_CIRCLE = 2'd0,
        OP_BOX_BOX       = 2'd1,
        OP_BOX_CIRCLE    = 2'd2,
        OP_CIRCLE_BOX    = 2'd3
    } cm2d_op_t;

    typedef struct packed {
        logic [1:0]          op;
        logic                hit;
        logic                bb_hit;
        logic signed [15:0]  bb_nx;
        logic signed [15:0]  bb_ny;
        logic [30:0]         bb_pen;
        logic signed [31:0]  qx;
        logic signed [31:0]  qy;
        logic [31:0]         mx;
        logic [31:0]         my;
        logic [30:0]         s_sum;
        logic [29:0]         rb;
        logic signed [31:0]  ox;
        logic signed [31:0]  oy;
        logic [31:0]         rdist;
        logic [30:0]         pen;
        logic signed [33:0]  len;
    } cm2d_ctx_t;

endpackage
`default_nettype wire

/* hdl/cm2d_front.sv */
`default_nettype none
module cm2d_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [1:0]            operation,
    input  logic signed [31:0]    a_x,
    input  logic signed [31:0]    a_y,
    input  logic signed [31:0]    b_x,
    input  logic signed [31:0]    b_y,
    input  logic [29:0]           a_size_x,
    input  logic [29:0]           a_size_y,
    input  logic [29:0]           b_size_x,
    input  logic [29:0]           b_size_y,
    output logic                  d_valid,
    output cm2d_pkg::cm2d_ctx_t   d_ctx,
    output logic [63:0]           d_dsq
);
    import cm2d_pkg::*;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v[32] != v[31])
            res = v[32] ? 32'sh80000000 : 32'sh7fffffff;
        else
            res = $signed(v[31:0]);
        return res;
    endfunction

    // distance from d to the interval [-lim, lim]
    function automatic logic signed [31:0] clamp_diff(input logic signed [31:0] d,
                                                      input logic [28:0] lim);
        logic signed [32:0] de;
        logic signed [32:0] le;
        logic signed [32:0] cl;
        logic signed [32:0] q;
        de = {d[31], d};
        le = $signed({4'b0, lim});
        if (de > le)
            cl = le;
        else if (de < -le)
            cl = -le;
        else
            cl = de;
        q = de - cl;
        return q[31:0];
    endfunction

    // stage A
    logic               a_valid_reg;
    logic [1:0]         a_op_reg;
    logic signed [31:0] a_dx_reg, a_dy_reg, a_ox_reg, a_oy_reg;
    logic [29:0]        a_asx_reg, a_asy_reg, a_bsx_reg, a_bsy_reg;
    logic signed [32:0] dx_wide, dy_wide;

    always_comb
    begin
        if (operation == OP_CIRCLE_BOX)
        begin
            dx_wide = $signed({a_x[31], a_x}) - $signed({b_x[31], b_x});
            dy_wide = $signed({a_y[31], a_y}) - $signed({b_y[31], b_y});
        end
        else
        begin
            dx_wide = $signed({b_x[31], b_x}) - $signed({a_x[31], a_x});
            dy_wide = $signed({b_y[31], b_y}) - $signed({a_y[31], a_y});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg  <= operation;
            a_dx_reg  <= sat33(dx_wide);
            a_dy_reg  <= sat33(dy_wide);
            a_ox_reg  <= (operation == OP_BOX_CIRCLE) ? b_x : a_x;
            a_oy_reg  <= (operation == OP_BOX_CIRCLE) ? b_y : a_y;
            a_asx_reg <= a_size_x;
            a_asy_reg <= a_size_y;
            a_bsx_reg <= b_size_x;
            a_bsy_reg <= b_size_y;
        end
    end

    // stage B: closest-point offsets, magnitudes, box-box result
    logic               b_valid_reg;
    cm2d_ctx_t          b_ctx_reg;
    cm2d_ctx_t          b_ctx_next;
    logic [29:0]        w, h, r;
    logic [31:0]        adx, ady;
    logic signed [34:0] px2, py2;
    logic signed [31:0] qx, qy;

    always_comb
    begin
        b_ctx_next = '0;
        w = (a_op_reg == OP_CIRCLE_BOX) ? a_bsx_reg : a_asx_reg;
        h = (a_op_reg == OP_CIRCLE_BOX) ? a_bsy_reg : a_asy_reg;
        r = (a_op_reg == OP_CIRCLE_BOX) ? a_asx_reg : a_bsx_reg;
        if (a_op_reg == OP_BOX_CIRCLE || a_op_reg == OP_CIRCLE_BOX)
        begin
            qx = clamp_diff(a_dx_reg, w[29:1]);
            qy = clamp_diff(a_dy_reg, h[29:1]);
        end
        else
        begin
            qx = a_dx_reg;
            qy = a_dy_reg;
        end
        adx = a_dx_reg[31] ? (~a_dx_reg + 32'd1) : a_dx_reg;
        ady = a_dy_reg[31] ? (~a_dy_reg + 32'd1) : a_dy_reg;
        px2 = $signed({5'b0, a_asx_reg} + {5'b0, a_bsx_reg} - {2'b0, adx, 1'b0});
        py2 = $signed({5'b0, a_asy_reg} + {5'b0, a_bsy_reg} - {2'b0, ady, 1'b0});

        b_ctx_next.op = a_op_reg;
        b_ctx_next.qx = qx;
        b_ctx_next.qy = qy;
        b_ctx_next.mx = qx[31] ? (~qx + 32'd1) : qx;
        b_ctx_next.my = qy[31] ? (~qy + 32'd1) : qy;
        b_ctx_next.s_sum = (a_op_reg == OP_CIRCLE_CIRCLE) ?
                           ({1'b0, a_asx_reg} + {1'b0, a_bsx_reg}) : {1'b0, r};
        b_ctx_next.rb = a_bsx_reg;
        b_ctx_next.ox = a_ox_reg;
        b_ctx_next.oy = a_oy_reg;
        if (px2 > 35'sd0 && py2 > 35'sd0)
        begin
            b_ctx_next.bb_hit = 1'b1;
            // least overlap axis, x on a tie
            if (py2 < px2)
            begin
                b_ctx_next.bb_ny  = a_dy_reg[31] ? NORM_NEG : NORM_POS;
                b_ctx_next.bb_pen = py2[31:1];
            end
            else
            begin
                b_ctx_next.bb_nx  = a_dx_reg[31] ? NORM_NEG : NORM_POS;
                b_ctx_next.bb_pen = px2[31:1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            b_ctx_reg <= b_ctx_next;
    end

    // stage C: squares
    logic        c_valid_reg;
    cm2d_ctx_t   c_ctx_reg;
    logic [63:0] c_sqx_reg, c_sqy_reg;
    logic [61:0] c_ssq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_ctx_reg <= b_ctx_reg;
            c_sqx_reg <= b_ctx_reg.mx * b_ctx_reg.mx;
            c_sqy_reg <= b_ctx_reg.my * b_ctx_reg.my;
            c_ssq_reg <= b_ctx_reg.s_sum * b_ctx_reg.s_sum;
        end
    end

    // stage D: squared distance and contact decision
    logic        d_valid_reg;
    cm2d_ctx_t   d_ctx_reg;
    cm2d_ctx_t   d_ctx_next;
    logic [63:0] d_dsq_reg;
    logic [63:0] dsq;

    always_comb
    begin
        dsq = c_sqx_reg + c_sqy_reg;
        d_ctx_next = c_ctx_reg;
        if (c_ctx_reg.op == OP_BOX_BOX)
            d_ctx_next.hit = c_ctx_reg.bb_hit;
        else
            d_ctx_next.hit = (dsq <= {2'b0, c_ssq_reg}) &&
                             !(c_ctx_reg.op == OP_CIRCLE_CIRCLE && dsq == 64'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_ctx_reg <= d_ctx_next;
            d_dsq_reg <= dsq;
        end
    end

    assign d_valid = d_valid_reg;
    assign d_ctx   = d_ctx_reg;
    assign d_dsq   = d_dsq_reg;

endmodule
`default_nettype wire

/* hdl/cm2d_sqrt.sv */
`default_nettype none
module cm2d_sqrt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  cm2d_pkg::cm2d_ctx_t   in_ctx,
    input  logic [63:0]           radicand,
    output logic                  out_valid,
    output cm2d_pkg::cm2d_ctx_t   out_ctx,
    output logic [31:0]           root
);
    import cm2d_pkg::*;

    logic        sq_valid_reg [SQRT_STAGES];
    cm2d_ctx_t   sq_ctx_reg   [SQRT_STAGES];
    logic [63:0] sq_rem_reg   [SQRT_STAGES];
    logic [63:0] sq_root_reg  [SQRT_STAGES];

    genvar k;
    for (k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STAGES - 1 - k));
        logic        v_in;
        cm2d_ctx_t   c_in;
        logic [63:0] rem_in, root_in, trial, rem_next, root_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign c_in    = in_ctx;
            assign rem_in  = radicand;
            assign root_in = 64'd0;
        end
        else
        begin : g_rest
            assign v_in    = sq_valid_reg[k-1];
            assign c_in    = sq_ctx_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
        end

        // one result bit per stage
        always_comb
        begin
            trial = root_in + BIT;
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = (root_in >> 1) + BIT;
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[k] <= 1'b0;
            else if (en)
                sq_valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_ctx_reg[k]  <= c_in;
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
            end
        end
    end

    assign out_valid = sq_valid_reg[SQRT_STAGES-1];
    assign out_ctx   = sq_ctx_reg[SQRT_STAGES-1];
    assign root      = sq_root_reg[SQRT_STAGES-1][31:0];

endmodule
`default_nettype wire

/* hdl/cm2d_div.sv */
`default_nettype none
module cm2d_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  cm2d_pkg::cm2d_ctx_t   in_ctx,
    input  logic [31:0]           rdist,
    output logic                  out_valid,
    output cm2d_pkg::cm2d_ctx_t   out_ctx,
    output logic [cm2d_pkg::DIV_STAGES-1:0] quot_x,
    output logic [cm2d_pkg::DIV_STAGES-1:0] quot_y
);
    import cm2d_pkg::*;

    localparam int NUM_W = 32 + DIV_STAGES;

    // prep stage: depth, point length, rounded numerators
    logic             p_valid_reg;
    cm2d_ctx_t        p_ctx_reg;
    cm2d_ctx_t        p_ctx_next;
    logic [NUM_W-1:0] p_numx_reg, p_numy_reg;
    logic [31:0]      p_den_reg;

    always_comb
    begin
        p_ctx_next       = in_ctx;
        p_ctx_next.rdist = rdist;
        p_ctx_next.pen   = in_ctx.s_sum - rdist[30:0];
        if (in_ctx.op == OP_CIRCLE_CIRCLE)
            p_ctx_next.len = $signed({2'b0, rdist}) - $signed({4'b0, in_ctx.rb});
        else
            p_ctx_next.len = -$signed({3'b0, in_ctx.s_sum});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ctx_reg  <= p_ctx_next;
            p_numx_reg <= {1'b0, in_ctx.mx, {(DIV_STAGES-1){1'b0}}} +
                          {{(DIV_STAGES+1){1'b0}}, rdist[31:1]};
            p_numy_reg <= {1'b0, in_ctx.my, {(DIV_STAGES-1){1'b0}}} +
                          {{(DIV_STAGES+1){1'b0}}, rdist[31:1]};
            p_den_reg  <= rdist;
        end
    end

    logic                  dv_valid_reg [DIV_STAGES];
    cm2d_ctx_t             dv_ctx_reg   [DIV_STAGES];
    logic [NUM_W-1:0]      dv_remx_reg  [DIV_STAGES];
    logic [NUM_W-1:0]      dv_remy_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] dv_qx_reg    [DIV_STAGES];
    logic [DIV_STAGES-1:0] dv_qy_reg    [DIV_STAGES];
    logic [31:0]           dv_den_reg   [DIV_STAGES];

    genvar j;
    for (j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        localparam int SH = DIV_STAGES - 1 - j;
        logic                  v_in;
        cm2d_ctx_t             c_in;
        logic [NUM_W-1:0]      rx_in, ry_in, rx_next, ry_next, dsh;
        logic [DIV_STAGES-1:0] qx_in, qy_in, qx_next, qy_next;
        logic [31:0]           den_in;

        if (j == 0)
        begin : g_first
            assign v_in   = p_valid_reg;
            assign c_in   = p_ctx_reg;
            assign rx_in  = p_numx_reg;
            assign ry_in  = p_numy_reg;
            assign qx_in  = '0;
            assign qy_in  = '0;
            assign den_in = p_den_reg;
        end
        else
        begin : g_rest
            assign v_in   = dv_valid_reg[j-1];
            assign c_in   = dv_ctx_reg[j-1];
            assign rx_in  = dv_remx_reg[j-1];
            assign ry_in  = dv_remy_reg[j-1];
            assign qx_in  = dv_qx_reg[j-1];
            assign qy_in  = dv_qy_reg[j-1];
            assign den_in = dv_den_reg[j-1];
        end

        // restoring step, one quotient bit per stage for each axis
        always_comb
        begin
            dsh     = {{DIV_STAGES{1'b0}}, den_in} << SH;
            rx_next = rx_in;
            ry_next = ry_in;
            qx_next = qx_in;
            qy_next = qy_in;
            if (rx_in >= dsh)
            begin
                rx_next     = rx_in - dsh;
                qx_next[SH] = 1'b1;
            end
            if (ry_in >= dsh)
            begin
                ry_next     = ry_in - dsh;
                qy_next[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j] <= 1'b0;
            else if (en)
                dv_valid_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_ctx_reg[j]  <= c_in;
                dv_remx_reg[j] <= rx_next;
                dv_remy_reg[j] <= ry_next;
                dv_qx_reg[j]   <= qx_next;
                dv_qy_reg[j]   <= qy_next;
                dv_den_reg[j]  <= den_in;
            end
        end
    end

    assign out_valid = dv_valid_reg[DIV_STAGES-1];
    assign out_ctx   = dv_ctx_reg[DIV_STAGES-1];
    assign quot_x    = dv_qx_reg[DIV_STAGES-1];
    assign quot_y    = dv_qy_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

/* hdl/cm2d_back.sv */
`default_nettype none
module cm2d_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  cm2d_pkg::cm2d_ctx_t   in_ctx,
    input  logic [cm2d_pkg::DIV_STAGES-1:0] quot_x,
    input  logic [cm2d_pkg::DIV_STAGES-1:0] quot_y,
    output logic                  out_valid,
    output logic                  contact,
    output logic signed [15:0]    normal_x,
    output logic signed [15:0]    normal_y,
    output logic [30:0]           penetration,
    output logic                  point_valid,
    output logic signed [31:0]    point_x,
    output logic signed [31:0]    point_y
);
    import cm2d_pkg::*;

    function automatic logic signed [31:0] sat38(input logic signed [37:0] v);
        logic signed [31:0] res;
        if (v > 38'sd2147483647)
            res = 32'sh7fffffff;
        else if (v < -38'sd2147483648)
            res = 32'sh80000000;
        else
            res = $signed(v[31:0]);
        return res;
    endfunction

    function automatic logic signed [36:0] round_q14(input logic signed [49:0] p);
        logic [49:0] m;
        logic [49:0] mr;
        logic [35:0] q;
        m  = p[49] ? (~p + 50'd1) : p;
        mr = m + (50'd1 << (ROUND_SHIFT - 1));
        q  = mr[49:ROUND_SHIFT];
        return p[49] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // stage F: signed normal, point product
    logic               f_valid_reg;
    cm2d_ctx_t          f_ctx_reg;
    logic signed [15:0] f_nx_reg, f_ny_reg;
    logic signed [49:0] f_px_reg, f_py_reg;
    logic signed [15:0] nx, ny, mag_x, mag_y;

    always_comb
    begin
        mag_x = $signed({1'b0, quot_x});
        mag_y = $signed({1'b0, quot_y});
        if (in_ctx.rdist == 32'd0)
        begin
            nx = '0;
            ny = '0;
        end
        else
        begin
            nx = in_ctx.qx[31] ? -mag_x : mag_x;
            ny = in_ctx.qy[31] ? -mag_y : mag_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (en)
            f_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_ctx_reg <= in_ctx;
            f_nx_reg  <= nx;
            f_ny_reg  <= ny;
            f_px_reg  <= nx * in_ctx.len;
            f_py_reg  <= ny * in_ctx.len;
        end
    end

    // stage G: round the point offset
    logic               g_valid_reg;
    cm2d_ctx_t          g_ctx_reg;
    logic signed [15:0] g_nx_reg, g_ny_reg;
    logic signed [36:0] g_offx_reg, g_offy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (en)
            g_valid_reg <= f_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_ctx_reg  <= f_ctx_reg;
            g_nx_reg   <= f_nx_reg;
            g_ny_reg   <= f_ny_reg;
            g_offx_reg <= round_q14(f_px_reg);
            g_offy_reg <= round_q14(f_py_reg);
        end
    end

    // stage H: output register
    logic               h_valid_reg;
    logic               h_contact_reg, h_contact_next;
    logic signed [15:0] h_nx_reg, h_nx_next, h_ny_reg, h_ny_next;
    logic [30:0]        h_pen_reg, h_pen_next;
    logic               h_pv_reg, h_pv_next;
    logic signed [31:0] h_px_reg, h_px_next, h_py_reg, h_py_next;
    logic signed [37:0] sum_x, sum_y;

    always_comb
    begin
        sum_x = $signed({{6{g_ctx_reg.ox[31]}}, g_ctx_reg.ox}) +
                $signed({g_offx_reg[36], g_offx_reg});
        sum_y = $signed({{6{g_ctx_reg.oy[31]}}, g_ctx_reg.oy}) +
                $signed({g_offy_reg[36], g_offy_reg});
        h_contact_next = 1'b0;
        h_nx_next      = '0;
        h_ny_next      = '0;
        h_pen_next     = '0;
        h_pv_next      = 1'b0;
        h_px_next      = '0;
        h_py_next      = '0;
        if (g_ctx_reg.hit)
        begin
            h_contact_next = 1'b1;
            if (g_ctx_reg.op == OP_BOX_BOX)
            begin
                h_nx_next  = g_ctx_reg.bb_nx;
                h_ny_next  = g_ctx_reg.bb_ny;
                h_pen_next = g_ctx_reg.bb_pen;
            end
            else
            begin
                // circle-box reports the normal from A toward B: flip it
                h_nx_next  = (g_ctx_reg.op == OP_CIRCLE_BOX) ? -g_nx_reg : g_nx_reg;
                h_ny_next  = (g_ctx_reg.op == OP_CIRCLE_BOX) ? -g_ny_reg : g_ny_reg;
                h_pen_next = g_ctx_reg.pen;
                h_pv_next  = 1'b1;
                h_px_next  = sat38(sum_x);
                h_py_next  = sat38(sum_y);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_valid_reg <= 1'b0;
        else if (en)
            h_valid_reg <= g_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_contact_reg <= h_contact_next;
            h_nx_reg      <= h_nx_next;
            h_ny_reg      <= h_ny_next;
            h_pen_reg     <= h_pen_next;
            h_pv_reg      <= h_pv_next;
            h_px_reg      <= h_px_next;
            h_py_reg      <= h_py_next;
        end
    end

    assign out_valid   = h_valid_reg;
    assign contact     = h_contact_reg;
    assign normal_x    = h_nx_reg;
    assign normal_y    = h_ny_reg;
    assign penetration = h_pen_reg;
    assign point_valid = h_pv_reg;
    assign point_x     = h_px_reg;
    assign point_y     = h_py_reg;

endmodule
`default_nettype wire

/* hdl/contact_manifold_2d.sv */
// Pipeline: 4 front stages, 32 square-root stages at one root bit each,
// 16 divider stages and 3 back stages.
// Throughput: one item per cycle; the whole pipeline freezes while a result
// waits under out_stall, so in_stall follows the output register.
// Reset: rst_n asynchronous, active low; clears every stage valid bit only.
`default_nettype none
module contact_manifold_2d (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          operation,
    input  logic signed [31:0]  a_x,
    input  logic signed [31:0]  a_y,
    input  logic signed [31:0]  b_x,
    input  logic signed [31:0]  b_y,
    input  logic [29:0]         a_size_x,
    input  logic [29:0]         a_size_y,
    input  logic [29:0]         b_size_x,
    input  logic [29:0]         b_size_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                contact,
    output logic signed [15:0]  normal_x,
    output logic signed [15:0]  normal_y,
    output logic [30:0]         penetration,
    output logic                point_valid,
    output logic signed [31:0]  point_x,
    output logic signed [31:0]  point_y
);
    import cm2d_pkg::*;

    logic                  en;
    logic                  fr_valid, sq_valid, dv_valid;
    cm2d_ctx_t             fr_ctx, sq_ctx, dv_ctx;
    logic [63:0]           fr_dsq;
    logic [31:0]           sq_root;
    logic [DIV_STAGES-1:0] dv_qx, dv_qy;

    // hold every stage while the output item is refused
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    cm2d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .operation (operation),
        .a_x       (a_x),
        .a_y       (a_y),
        .b_x       (b_x),
        .b_y       (b_y),
        .a_size_x  (a_size_x),
        .a_size_y  (a_size_y),
        .b_size_x  (b_size_x),
        .b_size_y  (b_size_y),
        .d_valid   (fr_valid),
        .d_ctx     (fr_ctx),
        .d_dsq     (fr_dsq)
    );

    cm2d_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_ctx    (fr_ctx),
        .radicand  (fr_dsq),
        .out_valid (sq_valid),
        .out_ctx   (sq_ctx),
        .root      (sq_root)
    );

    cm2d_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_ctx    (sq_ctx),
        .rdist     (sq_root),
        .out_valid (dv_valid),
        .out_ctx   (dv_ctx),
        .quot_x    (dv_qx),
        .quot_y    (dv_qy)
    );

    cm2d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (dv_valid),
        .in_ctx      (dv_ctx),
        .quot_x      (dv_qx),
        .quot_y      (dv_qy),
        .out_valid   (out_valid),
        .contact     (contact),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .penetration (penetration),
        .point_valid (point_valid),
        .point_x     (point_x),
        .point_y     (point_y)
    );

endmodule
`default_nettype wire
